// File: rtl/nste_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the network size trimmed mean estimator.
// No dependencies.
package nste_pkg;

   localparam int DIST_W  = 32;
   localparam int PROBE_W = 31;
   localparam int EST_W   = 32;
   localparam int HELD_W  = 7;
   localparam int MOD_W   = 21;
   localparam int CFG_W   = 11;
   localparam int ADDR_W  = 2;

   localparam logic [10:0] OLD_MOD_Q10 = 11'd1229;
   localparam logic [10:0] FW_MOD_Q10  = 11'd1434;
   localparam logic [10:0] ONE_Q10     = 11'd1024;

   localparam logic [ADDR_W-1:0] CSR_SELF_FW  = 2'd0;
   localparam logic [ADDR_W-1:0] CSR_FW_SHARE = 2'd1;
   localparam logic [ADDR_W-1:0] CSR_NV_SHARE = 2'd2;

   typedef struct packed {
      logic shift;
      logic write;
      logic load_tok;
      logic rotate;
      logic count;
   } cell_ctrl_type;

endpackage

// File: rtl/nste_cell.sv
`timescale 1ns / 1ps
// One window cell: a held probe plus a circulating token that gathers its rank.
// Depends on nste_pkg.
module nste_cell import nste_pkg::*; #(
   parameter int RK_W = 7
) (
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic               wsel,
   input  logic               vld,
   input  logic [PROBE_W-1:0] probe,
   input  logic [PROBE_W-1:0] nxt_val,
   input  logic [PROBE_W-1:0] tok_val_i,
   input  logic               tok_vld_i,
   input  logic [RK_W-1:0]    tok_rank_i,
   output logic [PROBE_W-1:0] val,
   output logic [PROBE_W-1:0] tok_val,
   output logic               tok_vld,
   output logic [RK_W-1:0]    tok_rank,
   output logic               match
);

   logic [PROBE_W-1:0] val_ff, val_in;
   logic [PROBE_W-1:0] tok_val_ff, tok_val_in;
   logic               tok_vld_ff, tok_vld_in;
   logic [RK_W-1:0]    tok_rank_ff, tok_rank_in;
   logic               less;

   assign less = vld && tok_vld_i && (val_ff < tok_val_i);

   always_comb begin
      val_in      = val_ff;
      tok_val_in  = tok_val_ff;
      tok_vld_in  = tok_vld_ff;
      tok_rank_in = tok_rank_ff;
      if (ctrl.shift) begin
         val_in = nxt_val;
      end
      if (ctrl.write && wsel) begin
         val_in = probe;
      end
      if (ctrl.load_tok) begin
         tok_val_in  = val_ff;
         tok_vld_in  = vld;
         tok_rank_in = '0;
      end else if (ctrl.rotate) begin
         tok_val_in  = tok_val_i;
         tok_vld_in  = tok_vld_i;
         tok_rank_in = tok_rank_i + RK_W'(ctrl.count && less);
      end
   end

   // rank counts on the token as it arrives
   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      tok_val_ff  <= tok_val_in;
      tok_vld_ff  <= tok_vld_in;
      tok_rank_ff <= tok_rank_in;
   end

   assign val      = val_ff;
   assign tok_val  = tok_val_ff;
   assign tok_vld  = tok_vld_ff;
   assign tok_rank = tok_rank_ff;
   assign match    = vld && (val_ff == probe);

endmodule

// File: rtl/nste_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on nste_pkg.
module nste_div import nste_pkg::*; #(
   parameter int DVD_W = 39
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [DIST_W-1:0] divisor,
   output logic              done,
   output logic [DVD_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  q_ff, q_in;
   logic [DIST_W:0]   rem_ff, rem_in;
   logic [DIST_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DIST_W:0]   trial;
   logic [DIST_W+1:0] diff;

   assign trial = {rem_ff[DIST_W-1:0], q_ff[DVD_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DVD_W);
      end else if (cnt_ff != '0) begin
         if (diff[DIST_W+1]) begin
            rem_in = trial;
            q_in   = {q_ff[DVD_W-2:0], 1'b0};
         end else begin
            rem_in = diff[DIST_W:0];
            q_in   = {q_ff[DVD_W-2:0], 1'b1};
         end
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: rtl/network_size_trimmed_mean_estimator.sv
`timescale 1ns / 1ps
// Network size estimator: top level with the probe window cell row, divider and control.
// Depends on nste_pkg, nste_cell and nste_div.
//
// Each transaction on req carries the top 32 bits of a closest distance; one transaction
// on rsp follows with the estimate and the number of probes held. One item is worked at
// a time. A nonzero distance runs a division of DVD_W steps (the width of the probe sum,
// 38 at the default depth), then the INS and CHK states insert the probe and check the
// fill. With at least MIN_PROBES held, a pass circles tokens round the cell row to rank
// the probes, a second pass sums the kept ones, and a second division of DVD_W steps and
// the MOD, MUL and OUT states for scaling and output follow. Below MIN_PROBES the estimate
// is zero and the result is sent from CHK through OUT. A result waiting on rsp does not
// stop the next request being taken, but holds the following one at its output.
// Configuration is to be written by the user only while idle; the block itself does not
// enforce this.
module network_size_trimmed_mean_estimator import nste_pkg::*; #(
   parameter int WINDOW_DEPTH = 100,
   parameter int MIN_PROBES   = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // distance_top
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // user_estimate, probes_held, zero pad
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]  csr_wdata
);

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int RK_W   = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = PROBE_W + FILL_W;
   localparam int DVD_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;
   localparam int CUT_W  = FILL_W + 8;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DIV1 = 4'd1;
   localparam logic [3:0] ST_INS  = 4'd2;
   localparam logic [3:0] ST_CHK  = 4'd3;
   localparam logic [3:0] ST_RANK = 4'd4;
   localparam logic [3:0] ST_SUM  = 4'd5;
   localparam logic [3:0] ST_DIV2 = 4'd6;
   localparam logic [3:0] ST_MOD  = 4'd7;
   localparam logic [3:0] ST_MUL  = 4'd8;
   localparam logic [3:0] ST_OUT  = 4'd9;

   logic [3:0]              state_ff, state_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [FILL_W-1:0]       wr_idx;
   logic [RK_W-1:0]         cnt_ff, cnt_in;
   logic [FILL_W-1:0]       cut_ff, cut_in;
   logic [FILL_W-1:0]       hi_ff, hi_in;
   logic [FILL_W-1:0]       kept_ff, kept_in;
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic [PROBE_W-1:0]      probe_ff, probe_in;
   logic [DIST_W-1:0]       dist_ff, dist_in;
   logic [PROBE_W-1:0]      mean_ff, mean_in;
   logic [MOD_W-1:0]        q20_ff, q20_in;
   logic [PROBE_W+MOD_W-1:0] prod_ff, prod_in;
   logic [EST_W-1:0]        est_ff, est_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [39:0]             rsp_data_ff, rsp_data_in;
   logic                    fw_ff;
   logic [9:0]              fw_share_ff;
   logic [10:0]             nv_share_ff;

   logic                    div_start;
   logic [DVD_W-1:0]        div_dvd;
   logic [DIST_W-1:0]       div_dvs;
   logic                    div_done;
   logic [DVD_W-1:0]        div_quo;

   cell_ctrl_type           ctrl;
   logic [PROBE_W-1:0]      c_val   [WINDOW_DEPTH];
   logic [PROBE_W-1:0]      c_tval  [WINDOW_DEPTH];
   logic                    c_tvld  [WINDOW_DEPTH];
   logic [RK_W-1:0]         c_trank [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] c_match;
   logic                    held;
   logic [CUT_W-1:0]        cut_prod;
   logic [FILL_W-1:0]       tok_rank_ext;
   logic [10:0]             r_sat;
   logic [10:0]             new_mod;
   logic [21:0]             mix;

   assign held = |c_match;

   // cells, oldest probe in cell 0; tokens move towards cell 0 round a ring
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic [PROBE_W-1:0] nxt;
      if (i == WINDOW_DEPTH - 1) begin : g_last
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = c_val[i+1];
      end
      nste_cell #(.RK_W(RK_W)) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .wsel       (wr_idx == FILL_W'(i)),
         .vld        (FILL_W'(i) < fill_ff),
         .probe      (probe_ff),
         .nxt_val    (nxt),
         .tok_val_i  (c_tval[(i + 1) % WINDOW_DEPTH]),
         .tok_vld_i  (c_tvld[(i + 1) % WINDOW_DEPTH]),
         .tok_rank_i (c_trank[(i + 1) % WINDOW_DEPTH]),
         .val        (c_val[i]),
         .tok_val    (c_tval[i]),
         .tok_vld    (c_tvld[i]),
         .tok_rank   (c_trank[i]),
         .match      (c_match[i])
      );
   end

   nste_div #(.DVD_W(DVD_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign wr_idx       = (fill_ff == FILL_W'(WINDOW_DEPTH)) ? FILL_W'(WINDOW_DEPTH - 1) : fill_ff;
   assign cut_prod     = CUT_W'(fill_ff) * CUT_W'(171);
   assign tok_rank_ext = FILL_W'(c_trank[0]);
   assign r_sat        = (nv_share_ff > ONE_Q10) ? ONE_Q10 : nv_share_ff;
   assign new_mod      = fw_ff ? FW_MOD_Q10
                       : (fw_share_ff != '0) ? (ONE_Q10 + 11'(fw_share_ff)) : '0;
   assign mix          = 22'(r_sat) * 22'(new_mod)
                       + 22'(ONE_Q10 - r_sat) * 22'(OLD_MOD_Q10);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      cnt_in      = cnt_ff;
      cut_in      = cut_ff;
      hi_in       = hi_ff;
      kept_in     = kept_ff;
      acc_in      = acc_ff;
      probe_in    = probe_ff;
      dist_in     = dist_ff;
      mean_in     = mean_ff;
      q20_in      = q20_ff;
      prod_in     = prod_ff;
      est_in      = est_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      ctrl        = '0;
      div_start   = 1'b0;
      div_dvd     = DVD_W'(dist_ff);
      div_dvs     = dist_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dist_in = req_tdata;
               if (req_tdata != '0) begin
                  div_start = 1'b1;
                  div_dvd   = DVD_W'(32'hFFFF_FFFF);
                  div_dvs   = req_tdata;
                  state_in  = ST_DIV1;
               end else begin
                  state_in = ST_CHK;
               end
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               probe_in = div_quo[PROBE_W:1];
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            if (!held) begin
               ctrl.write = 1'b1;
               if (fill_ff == FILL_W'(WINDOW_DEPTH)) begin
                  ctrl.shift = 1'b1;
               end else begin
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (32'(fill_ff) < 32'(MIN_PROBES)) begin
               est_in   = '0;
               state_in = ST_OUT;
            end else begin
               ctrl.load_tok = 1'b1;
               cut_in   = FILL_W'(cut_prod >> 10);
               hi_in    = fill_ff - FILL_W'(cut_prod >> 10);
               kept_in  = fill_ff - FILL_W'((cut_prod >> 10) << 1);
               cnt_in   = '0;
               state_in = ST_RANK;
            end
         end
         ST_RANK: begin
            ctrl.rotate = 1'b1;
            ctrl.count  = 1'b1;
            cnt_in      = cnt_ff + RK_W'(1);
            if (cnt_ff == RK_W'(WINDOW_DEPTH - 1)) begin
               cnt_in   = '0;
               acc_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            ctrl.rotate = 1'b1;
            if (c_tvld[0] && (tok_rank_ext >= cut_ff) && (tok_rank_ext < hi_ff)) begin
               acc_in = acc_ff + SUM_W'(c_tval[0]);
            end
            cnt_in = cnt_ff + RK_W'(1);
            if (cnt_ff == RK_W'(WINDOW_DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_DIV2;
               div_start = 1'b1;
               div_dvd   = DVD_W'(acc_in);
               div_dvs   = DIST_W'(kept_ff);
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               mean_in  = div_quo[PROBE_W-1:0];
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if ((r_sat != '0) && (new_mod != '0)) begin
               q20_in = MOD_W'(mix);
            end else begin
               q20_in = MOD_W'(22'(OLD_MOD_Q10) * 22'(ONE_Q10));
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = (PROBE_W + MOD_W)'(mean_ff) * (PROBE_W + MOD_W)'(q20_ff);
            state_in = ST_OUT;
            est_in   = EST_W'(prod_in >> 20);
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {1'b0, HELD_W'(fill_ff), est_ff};
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         cnt_ff      <= '0;
         rsp_vld_ff  <= 1'b0;
         fw_ff       <= 1'b0;
         fw_share_ff <= '0;
         nv_share_ff <= '0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SELF_FW:  fw_ff       <= csr_wdata[0];
               CSR_FW_SHARE: fw_share_ff <= csr_wdata[9:0];
               CSR_NV_SHARE: nv_share_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      cut_ff      <= cut_in;
      hi_ff       <= hi_in;
      kept_ff     <= kept_in;
      acc_ff      <= acc_in;
      probe_ff    <= probe_in;
      dist_ff     <= dist_in;
      mean_ff     <= mean_in;
      q20_ff      <= q20_in;
      prod_ff     <= prod_in;
      est_ff      <= est_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
